### rtl/core/arpc_pkg.sv
// ============================================================================
// arpc_pkg
// Shared types and constants for the ARP responder with address cache.
// ============================================================================
package arpc_pkg;

    // Cache geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int CACHE_IDX_W   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // Item kinds
    localparam logic [1:0] KIND_RX      = 2'd0;
    localparam logic [1:0] KIND_RESOLVE = 2'd1;
    localparam logic [1:0] KIND_STORE   = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_NONE     = 2'd0;
    localparam logic [1:0] RES_REPLY    = 2'd1;
    localparam logic [1:0] RES_REQUEST  = 2'd2;
    localparam logic [1:0] RES_RESOLVED = 2'd3;

    // ARP header values
    localparam logic [15:0] ARP_HW_ETHERNET = 16'h0001;
    localparam logic [15:0] ARP_PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  ARP_HW_LEN      = 8'd6;
    localparam logic [7:0]  ARP_PROTO_LEN   = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST  = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY    = 16'd2;

    // Outgoing opcodes
    localparam logic [1:0] TX_OP_NONE    = 2'd0;
    localparam logic [1:0] TX_OP_REQUEST = 2'd1;
    localparam logic [1:0] TX_OP_REPLY   = 2'd2;

    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

    // Configuration register indexes
    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    // Input word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
        logic        frame_truncated;
    } t_arp_in;

    // Result word
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  tx_opcode;
        logic [47:0] tx_sender_mac;
        logic [31:0] tx_sender_ip;
        logic [47:0] tx_target_mac;
        logic [31:0] tx_target_ip;
        logic [47:0] resolved_mac;
    } t_arp_out;

    // Cache access request and response
    typedef struct packed {
        logic        store;
        logic [31:0] key;
        logic [47:0] mac;
    } t_cache_req;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac;
    } t_cache_rsp;

endpackage

### rtl/core/arpc_cfg.sv
// ============================================================================
// arpc_cfg
// APB register file holding this station's IPv4 and MAC addresses.
// ============================================================================
module arpc_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [31:0] o_own_ip,
    output logic [47:0] o_own_mac
);

    logic [31:0] r_own_ip;
    logic [47:0] r_own_mac;
    logic        wr_en;
    logic        reg_sel;

    // registers sit at 8-byte spacing
    assign reg_sel = paddr[3];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_own_mac <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                arpc_pkg::REG_OWN_IP:  r_own_ip  <= pwdata[31:0];
                arpc_pkg::REG_OWN_MAC: r_own_mac <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            arpc_pkg::REG_OWN_IP:  prdata = {32'd0, r_own_ip};
            arpc_pkg::REG_OWN_MAC: prdata = {16'd0, r_own_mac};
            default:               prdata = '0;
        endcase
    end

    assign o_own_ip  = r_own_ip;
    assign o_own_mac = r_own_mac;

endmodule

### rtl/core/arpc_cache.sv
// ============================================================================
// arpc_cache
// IPv4-to-MAC cache: parallel lookup, update in place, fill lowest free
// entry, round-robin replacement when full.
// ============================================================================
module arpc_cache (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  arpc_pkg::t_cache_req  i_req,
    output arpc_pkg::t_cache_rsp  o_rsp
);

    localparam int N = arpc_pkg::CACHE_ENTRIES;
    localparam int W = arpc_pkg::CACHE_IDX_W;

    logic [N-1:0]  r_valid;
    logic [31:0]   r_ip  [N];
    logic [47:0]   r_mac [N];
    logic [W-1:0]  r_ptr;
    logic [W-1:0]  n_ptr;

    logic [N-1:0]  match;
    logic [N-1:0]  match_1h;
    logic [N-1:0]  free_1h;
    logic [N-1:0]  ptr_1h;
    logic [N-1:0]  wr_1h;
    logic          any_free;
    logic          new_key;
    logic          advance;
    logic [47:0]   hit_mac;

    // compare all entries against the key
    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = r_valid[i] & (r_ip[i] == i_req.key);
        end
    end

    // lowest set bit selects
    assign match_1h = match & (~match + N'(1));
    assign free_1h  = ~r_valid & (r_valid + N'(1));
    assign any_free = ~&r_valid;
    assign ptr_1h   = N'(1) << r_ptr;

    always_comb begin
        hit_mac = '0;
        for (int i = 0; i < N; i++) begin
            hit_mac = hit_mac | (match_1h[i] ? r_mac[i] : 48'd0);
        end
    end

    assign o_rsp.hit = |match;
    assign o_rsp.mac = hit_mac;

    // choose entry to write
    assign new_key = i_req.store & ~(|match);
    assign advance = new_key & ~any_free;

    always_comb begin
        if (!i_req.store) begin
            wr_1h = '0;
        end else if (|match) begin
            wr_1h = match_1h;
        end else if (any_free) begin
            wr_1h = free_1h;
        end else begin
            wr_1h = ptr_1h;
        end
    end

    // replacement pointer wraps at the cache size
    always_comb begin
        if (32'(r_ptr) == N - 1) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            if (new_key) begin
                r_valid <= r_valid | wr_1h;
            end
            if (advance) begin
                r_ptr <= n_ptr;
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (wr_1h[i]) begin
                r_mac[i] <= i_req.mac;
                if (new_key) begin
                    r_ip[i] <= i_req.key;
                end
            end
        end
    end

endmodule

### rtl/core/arp_responder_with_cache.sv
// ============================================================================
// arp_responder_with_cache
// Answers ARP requests for this station, learns ARP replies into an address
// cache, resolves IPv4 addresses from the cache and takes direct stores.
// ============================================================================
//
//  channel   ports                            handshake
//  --------  -------------------------------  ------------------------------
//  input     i_item                           start high, busy low
//  result    o_result                         o_valid, one cycle, no stall
//  config    psel penable pwrite paddr pwdata APB, pready always high
//
//  An item is registered in the input register on acceptance and its result
//  in the result register; one item per cycle, busy stays low.
//  The 16-entry cache is compared in parallel and written at the edge that
//  registers the result, so the next item already sees the update. Every
//  item yields one result. Synchronous reset clears the cache valid bits,
//  the replacement pointer and the configuration registers.
//
module arp_responder_with_cache (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  arpc_pkg::t_arp_in  i_item,
    output logic               o_valid,
    output arpc_pkg::t_arp_out o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [31:0]          own_ip;
    logic [47:0]          own_mac;

    logic                 r_in_vld;
    arpc_pkg::t_arp_in    r_in;
    logic                 r_out_vld;
    arpc_pkg::t_arp_out   r_out;
    arpc_pkg::t_arp_out   n_out;

    arpc_pkg::t_cache_req cache_req;
    arpc_pkg::t_cache_rsp cache_rsp;

    logic                 msg_ok;
    logic                 is_rx;
    logic                 rx_req;
    logic                 rx_rep;

    assign busy = 1'b0;

    arpc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_own_ip  (own_ip),
        .o_own_mac (own_mac)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_in <= i_item;
        end
    end

    // received message checks
    assign is_rx  = r_in.kind == arpc_pkg::KIND_RX;
    assign msg_ok = ~r_in.frame_truncated
                  & (r_in.hw_type    == arpc_pkg::ARP_HW_ETHERNET)
                  & (r_in.proto_type == arpc_pkg::ARP_PROTO_IPV4)
                  & (r_in.hw_len     == arpc_pkg::ARP_HW_LEN)
                  & (r_in.proto_len  == arpc_pkg::ARP_PROTO_LEN)
                  & (r_in.target_ip  == own_ip);
    assign rx_req = is_rx & msg_ok & (r_in.opcode == arpc_pkg::ARP_OP_REQUEST);
    assign rx_rep = is_rx & msg_ok & (r_in.opcode == arpc_pkg::ARP_OP_REPLY);

    // cache access: resolve looks up target IP, stores key on sender IP
    assign cache_req.store = r_in_vld & (rx_rep | (r_in.kind == arpc_pkg::KIND_STORE));
    assign cache_req.key   = (r_in.kind == arpc_pkg::KIND_RESOLVE) ? r_in.target_ip
                                                                    : r_in.sender_ip;
    assign cache_req.mac   = r_in.sender_mac;

    arpc_cache u_cache (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cache_req),
        .o_rsp   (cache_rsp)
    );

    // result word
    always_comb begin
        n_out = '0;
        case (r_in.kind)
            arpc_pkg::KIND_RX: begin
                if (rx_req) begin
                    n_out.result_kind   = arpc_pkg::RES_REPLY;
                    n_out.tx_opcode     = arpc_pkg::TX_OP_REPLY;
                    n_out.tx_sender_mac = own_mac;
                    n_out.tx_sender_ip  = own_ip;
                    n_out.tx_target_mac = r_in.sender_mac;
                    n_out.tx_target_ip  = r_in.sender_ip;
                end
            end
            arpc_pkg::KIND_RESOLVE: begin
                if (cache_rsp.hit) begin
                    n_out.result_kind  = arpc_pkg::RES_RESOLVED;
                    n_out.resolved_mac = cache_rsp.mac;
                end else begin
                    n_out.result_kind   = arpc_pkg::RES_REQUEST;
                    n_out.tx_opcode     = arpc_pkg::TX_OP_REQUEST;
                    n_out.tx_sender_mac = own_mac;
                    n_out.tx_sender_ip  = own_ip;
                    n_out.tx_target_mac = arpc_pkg::MAC_BROADCAST;
                    n_out.tx_target_ip  = r_in.target_ip;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

### dv/tb_arp_responder_with_cache.sv
// ----------------------------------------------------------------------------
// tb_arp_responder_with_cache
// Self-checking bench for the ARP responder. A scoreboard class keeps its own
// copy of the station registers and the 16-entry address cache. It predicts
// the answer word for every accepted input word and checks each result word
// field by field, in order. Stimulus starts with a short directed list and
// then runs random phases under several station settings. The random words
// are mostly well-formed ARP traffic, resolves and stores over a small address
// pool, so that the cache fills and wraps. The rest are broken messages and
// noise. Random gaps are placed between input words.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_cache;
    import arpc_pkg::*;

    // Predicts answer words and checks the block's result words against them
    class arp_answer_checker;
        t_arp_out    pending_answers[$];
        logic [31:0] own_ip;
        logic [47:0] own_mac;
        logic        learned_valid[CACHE_ENTRIES];
        logic [31:0] learned_ip[CACHE_ENTRIES];
        logic [47:0] learned_mac[CACHE_ENTRIES];
        int unsigned evict_ptr;
        int          mismatch_cnt;
        int          kind_seen[4];

        function new();
            own_ip       = '0;
            own_mac      = '0;
            evict_ptr    = 0;
            mismatch_cnt = 0;
            foreach (learned_valid[i]) learned_valid[i] = 1'b0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [63:0] value);
            if (idx == REG_OWN_IP) begin
                own_ip = value[31:0];
            end else begin
                own_mac = value[47:0];
            end
        endfunction

        // lowest valid entry holding this address, -1 if none
        function int find_entry(logic [31:0] ip);
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                if (learned_valid[i] && learned_ip[i] == ip) return i;
            end
            return -1;
        endfunction

        // update in place, else first free slot, else round-robin victim
        function void learn(logic [31:0] ip, logic [47:0] mac);
            int slot;
            slot = find_entry(ip);
            if (slot < 0) begin
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (!learned_valid[i] && slot < 0) slot = i;
                end
                if (slot < 0) begin
                    slot      = evict_ptr;
                    evict_ptr = (evict_ptr + 1) % CACHE_ENTRIES;
                end
                learned_valid[slot] = 1'b1;
                learned_ip[slot]    = ip;
            end
            learned_mac[slot] = mac;
        endfunction

        function t_arp_out predict_answer(t_arp_in w);
            t_arp_out r;
            int       hit;
            logic     ok;
            r = '0;
            case (w.kind)
                KIND_RX: begin
                    ok = !w.frame_truncated && w.hw_type == ARP_HW_ETHERNET &&
                         w.proto_type == ARP_PROTO_IPV4 && w.hw_len == ARP_HW_LEN &&
                         w.proto_len == ARP_PROTO_LEN && w.target_ip == own_ip;
                    if (ok && w.opcode == ARP_OP_REQUEST) begin
                        r.result_kind   = RES_REPLY;
                        r.tx_opcode     = TX_OP_REPLY;
                        r.tx_sender_mac = own_mac;
                        r.tx_sender_ip  = own_ip;
                        r.tx_target_mac = w.sender_mac;
                        r.tx_target_ip  = w.sender_ip;
                    end else if (ok && w.opcode == ARP_OP_REPLY) begin
                        learn(w.sender_ip, w.sender_mac);
                    end
                end
                KIND_RESOLVE: begin
                    hit = find_entry(w.target_ip);
                    if (hit >= 0) begin
                        r.result_kind  = RES_RESOLVED;
                        r.resolved_mac = learned_mac[hit];
                    end else begin
                        r.result_kind   = RES_REQUEST;
                        r.tx_opcode     = TX_OP_REQUEST;
                        r.tx_sender_mac = own_mac;
                        r.tx_sender_ip  = own_ip;
                        r.tx_target_mac = MAC_BROADCAST;
                        r.tx_target_ip  = w.target_ip;
                    end
                end
                KIND_STORE: begin
                    learn(w.sender_ip, w.sender_mac);
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_item(t_arp_in w);
            pending_answers.push_back(predict_answer(w));
        endfunction

        task report_mismatch(string msg);
            mismatch_cnt++;
            if (mismatch_cnt <= 40) $display("MISMATCH: %s", msg);
        endtask

        task cmp_field(string name, logic [47:0] got, logic [47:0] exp);
            if (got !== exp) begin
                report_mismatch($sformatf("%s got %h exp %h", name, got, exp));
            end
        endtask

        task check_answer(t_arp_out got);
            t_arp_out exp;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result word %h", got));
            end else begin
                exp = pending_answers.pop_front();
                kind_seen[exp.result_kind]++;
                cmp_field("result_kind", 48'(got.result_kind), 48'(exp.result_kind));
                cmp_field("tx_opcode", 48'(got.tx_opcode), 48'(exp.tx_opcode));
                cmp_field("tx_sender_mac", got.tx_sender_mac, exp.tx_sender_mac);
                cmp_field("tx_sender_ip", 48'(got.tx_sender_ip), 48'(exp.tx_sender_ip));
                cmp_field("tx_target_mac", got.tx_target_mac, exp.tx_target_mac);
                cmp_field("tx_target_ip", 48'(got.tx_target_ip), 48'(exp.tx_target_ip));
                cmp_field("resolved_mac", got.resolved_mac, exp.resolved_mac);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_arp_in     i_item;
    logic        o_valid;
    t_arp_out    o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    arp_answer_checker book = new();
    logic [31:0] cur_ip = '0;
    logic [31:0] ip_pool[24];
    int          words_sent = 0;
    int          settings_used = 0;

    arp_responder_with_cache dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1000000;
        $display("tb_arp_responder_with_cache NOT OK");
        $finish;
    end

    // result words are stable mid-cycle; each strobe spans exactly one negedge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid) book.check_answer(o_result);
    end

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        t = {$urandom(), $urandom()};
        return t[47:0];
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(0, 23)];
    endfunction

    // well-formed ARP message aimed at this station
    function automatic t_arp_in good_rx(logic [15:0] op, logic [31:0] sip,
                                        logic [47:0] smac);
        t_arp_in w;
        w.kind            = KIND_RX;
        w.hw_type         = ARP_HW_ETHERNET;
        w.proto_type      = ARP_PROTO_IPV4;
        w.hw_len          = ARP_HW_LEN;
        w.proto_len       = ARP_PROTO_LEN;
        w.opcode          = op;
        w.sender_mac      = smac;
        w.sender_ip       = sip;
        w.target_mac      = rand48();
        w.target_ip       = cur_ip;
        w.frame_truncated = 1'b0;
        return w;
    endfunction

    function automatic t_arp_in noise_word();
        t_arp_in w;
        w.kind            = 2'($urandom_range(0, 3));
        w.hw_type         = 16'($urandom);
        w.proto_type      = 16'($urandom);
        w.hw_len          = 8'($urandom);
        w.proto_len       = 8'($urandom);
        w.opcode          = 16'($urandom);
        w.sender_mac      = rand48();
        w.sender_ip       = $urandom;
        w.target_mac      = rand48();
        w.target_ip       = $urandom;
        w.frame_truncated = 1'($urandom);
        return w;
    endfunction

    function automatic t_arp_in random_word();
        t_arp_in w;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            w = good_rx(($urandom_range(0, 1) == 0) ? ARP_OP_REQUEST : ARP_OP_REPLY,
                        pool_ip(), rand48());
            if ($urandom_range(0, 9) == 0) w.target_ip = pool_ip();
        end else if (pick < 60) begin
            w           = noise_word();
            w.kind      = KIND_RESOLVE;
            w.target_ip = ($urandom_range(0, 4) != 0) ? pool_ip() : $urandom;
        end else if (pick < 78) begin
            w           = noise_word();
            w.kind      = KIND_STORE;
            w.sender_ip = pool_ip();
        end else if (pick < 90) begin
            // one corrupted check in an otherwise good message
            w = good_rx(($urandom_range(0, 1) == 0) ? ARP_OP_REQUEST : ARP_OP_REPLY,
                        pool_ip(), rand48());
            case ($urandom_range(0, 6))
                0: w.frame_truncated = 1'b1;
                1: w.hw_type = 16'($urandom);
                2: w.proto_type = 16'($urandom);
                3: w.hw_len = 8'($urandom);
                4: w.proto_len = 8'($urandom);
                5: w.opcode = 16'($urandom);
                default: w.target_ip = $urandom;
            endcase
        end else begin
            w = noise_word();
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // all tasks start and end just after a rising edge
    task automatic send_word(t_arp_in w);
        logic taken;
        start  <= 1'b1;
        i_item <= w;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        book.note_item(w);
        words_sent++;
    endtask

    // leaves psel high; the caller releases the bus after its last write
    task automatic apb_write(logic idx, logic [63:0] value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        book.set_reg(idx, value);
    endtask

    task automatic set_station(logic [31:0] ip, logic [47:0] mac);
        apb_write(REG_OWN_IP, 64'(ip));
        apb_write(REG_OWN_MAC, 64'(mac));
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_ip = ip;
        settings_used++;
    endtask

    // idle the input and let every expected word come back
    task automatic drain();
        start <= 1'b0;
        while (book.pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int n);
        int  gap;
        logic no_gaps;
        no_gaps = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (k % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            gap = no_gaps ? 0 : pick_gap();
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_word(random_word());
        end
    endtask

    initial begin
        t_arp_in w;
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [31:0] ip_c;
        logic [31:0] ip_d;
        logic [47:0] mac_a;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < 24; i++) ip_pool[i] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset station values: own address zero
        send_word(good_rx(ARP_OP_REQUEST, 32'h0A00_0002, 48'h0011_2233_4455));
        w = noise_word();
        w.kind = KIND_RESOLVE;
        send_word(w);
        drain();

        // directed: answer, learn, hit, miss, store and update
        set_station(32'hC0A8_0001, 48'h0200_0000_0001);
        ip_a  = 32'hC0A8_0010;
        ip_b  = 32'hC0A8_0020;
        ip_c  = 32'hC0A8_0030;
        ip_d  = 32'hC0A8_0040;
        mac_a = 48'h0A1B_2C3D_4E5F;
        send_word(good_rx(ARP_OP_REQUEST, ip_a, mac_a));
        send_word(good_rx(ARP_OP_REPLY, ip_a, '1));
        w = noise_word();
        w.kind = KIND_RESOLVE;
        w.target_ip = ip_a;
        send_word(w);
        w.target_ip = ip_b;
        send_word(w);
        w = noise_word();
        w.kind = KIND_STORE;
        w.sender_ip = ip_b;
        w.sender_mac = '0;
        send_word(w);
        w.sender_mac = mac_a;
        send_word(w);
        w.kind = KIND_RESOLVE;
        w.target_ip = ip_b;
        send_word(w);

        // each failed check drops a reply that would otherwise be learned
        for (int c = 0; c < 9; c++) begin
            w = good_rx(ARP_OP_REPLY, ip_c, mac_a);
            case (c)
                0: w.frame_truncated = 1'b1;
                1: w.hw_type = 16'hFFFF;
                2: w.proto_type = 16'h0008;
                3: w.hw_len = 8'h00;
                4: w.proto_len = 8'hFF;
                5: w.target_ip = ~cur_ip;
                6: w.opcode = 16'h0000;
                7: w.opcode = 16'h0003;
                default: w.opcode = 16'hFFFF;
            endcase
            send_word(w);
        end
        w = noise_word();
        w.kind = KIND_RESOLVE;
        w.target_ip = ip_c;
        send_word(w);

        // unknown kind must not store
        w = noise_word();
        w.kind = 2'd3;
        w.sender_ip = ip_d;
        send_word(w);
        w.kind = KIND_RESOLVE;
        w.target_ip = ip_d;
        send_word(w);

        // extreme addresses
        send_word(good_rx(ARP_OP_REQUEST, '1, '0));
        w = noise_word();
        w.kind = KIND_STORE;
        w.sender_ip = '0;
        w.sender_mac = '1;
        send_word(w);
        w.kind = KIND_RESOLVE;
        w.target_ip = '0;
        send_word(w);
        drain();

        // random phases under several station settings
        for (int p = 0; p < 6; p++) begin
            for (int i = 12; i < 24; i++) ip_pool[i] = $urandom;
            case (p)
                0: set_station('1, '1);
                1: set_station('0, '0);
                2: set_station($urandom, rand48());
                3: set_station($urandom, '0);
                4: set_station(ip_pool[$urandom_range(2, 11)], rand48());
                default: set_station(32'h0A00_0001, rand48());
            endcase
            run_phase(290);
            drain();
        end

        repeat (6) @(posedge i_clk);
        $display("covered %0d input words over %0d station settings", words_sent,
                 settings_used);
        $display("answers: %0d none, %0d replies, %0d requests, %0d cache hits",
                 book.kind_seen[RES_NONE], book.kind_seen[RES_REPLY],
                 book.kind_seen[RES_REQUEST], book.kind_seen[RES_RESOLVED]);
        if (book.mismatch_cnt == 0) begin
            $display("tb_arp_responder_with_cache OK");
        end else begin
            $display("tb_arp_responder_with_cache NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_cfg.sv
rtl/core/arpc_cache.sv
rtl/core/arp_responder_with_cache.sv
dv/tb_arp_responder_with_cache.sv
